// ===== design/cdtv_pkg.sv =====
// Shared types, constants and result codes for the CD full-TOC validator.
package cdtv_pkg;

    // Parse limits
    localparam int MAX_TOC_BYTES = 2048;
    localparam int CNT_W         = $clog2(MAX_TOC_BYTES + 1);
    localparam int DECL_W        = 17;
    localparam int HDR_LEN       = 4;
    localparam int REC_LEN       = 11;
    localparam int POS_W         = 4;

    // Field widths
    localparam int IMG_W   = 40;
    localparam int LEAD_W  = 22;
    localparam int BYTES_W = 32;

    // Descriptor codes
    localparam logic [7:0] FIRST_SESSION = 8'h01;
    localparam logic [7:0] POINT_TRK_LO  = 8'h01;
    localparam logic [7:0] POINT_TRK_HI  = 8'h63;
    localparam logic [7:0] POINT_A0      = 8'hA0;
    localparam logic [7:0] POINT_A1      = 8'hA1;
    localparam logic [7:0] POINT_A2      = 8'hA2;
    localparam logic [3:0] ADR_POS       = 4'd1;
    localparam logic [3:0] ADR_OTHER     = 4'd5;
    localparam logic [7:0] DISK_CDDA     = 8'h00;
    localparam logic [7:0] DISK_CDI      = 8'h10;
    localparam logic [7:0] DISK_XA       = 8'h20;
    localparam logic [7:0] SEC_LIMIT     = 8'd60;
    localparam logic [7:0] FRAME_LIMIT   = 8'd75;

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        ERR_OK            = 4'd0,
        ERR_TOO_LARGE     = 4'd1,
        ERR_FIRST_SESSION = 4'd2,
        ERR_SESSION       = 4'd3,
        ERR_TRACK_START   = 4'd4,
        ERR_ADR           = 4'd5,
        ERR_DISK_TYPE     = 4'd6,
        ERR_FIRST_TRACK   = 4'd7,
        ERR_LAST_TRACK    = 4'd8,
        ERR_RESERVED      = 4'd9,
        ERR_SIZE          = 4'd10,
        ERR_TRUNCATED     = 4'd11
    } t_err;

    // One job: a finished descriptor, an end-of-file marker, or both
    typedef struct packed {
        logic       rec_v;
        logic       fin_v;
        logic       too_large;
        logic       hdr_err;
        logic       trunc;
        logic [7:0] session;
        logic [3:0] adr;
        logic [7:0] point;
        logic [7:0] pmin;
        logic [7:0] psec;
        logic [7:0] pframe;
    } t_job;

endpackage

// ===== design/cd_clone_toc_validator.sv =====
// Top level of the CD full-TOC validator: config register, front, job queue, back.
//
//   channel   direction  handshake           beat contents
//   toc in    in         push / full         i_toc_byte, i_is_last
//   verdict   out        empty / pop         o_toc_valid, o_error_code, o_leadout_frames
//   config    in         i_cfg_wr_en         i_cfg_wr_data (image size in bytes)
//
// One byte is taken per cycle while full is low; full rises only when the
// four-entry job queue between the parser and the checker is full.
// The last byte's job passes through the queue, then the check, verdict and output stages;
// the checker drains one job per cycle unless the result register is held.
// Reset (i_rst_n low at a clock edge) clears the parse state, the queue and the
// image size register. Holding pop low stalls the checker, then fills the
// queue, and only then raises full.
module cd_clone_toc_validator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_toc_byte,
    input  logic                               i_is_last,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_toc_valid,
    output logic [3:0]                         o_error_code,
    output logic signed [cdtv_pkg::LEAD_W-1:0] o_leadout_frames,
    input  logic                               i_cfg_wr_en,
    input  logic [cdtv_pkg::IMG_W-1:0]         i_cfg_wr_data
);

    logic [cdtv_pkg::IMG_W-1:0] r_image_bytes;
    logic                       accept;
    logic                       job_push;
    cdtv_pkg::t_job             job_in;
    cdtv_pkg::t_job             job_head;
    logic                       job_empty;
    logic                       job_pop;

    assign accept = push && !full;

    // Hold the image size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes <= '0;
        end else if (i_cfg_wr_en) begin
            r_image_bytes <= i_cfg_wr_data;
        end
    end

    cdtv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_toc_byte (i_toc_byte),
        .i_is_last  (i_is_last),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    cdtv_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_empty (job_empty),
        .o_head  (job_head)
    );

    cdtv_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_v          (!job_empty),
        .i_job            (job_head),
        .o_job_pop        (job_pop),
        .i_image_bytes    (r_image_bytes),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_toc_valid      (o_toc_valid),
        .o_error_code     (o_error_code),
        .o_leadout_frames (o_leadout_frames)
    );

endmodule

// ===== design/cdtv_front.sv =====
// Front end: counts bytes, parses the header and gathers descriptors into jobs.
module cdtv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_toc_byte,
    input  logic              i_is_last,
    output logic              o_job_push,
    output cdtv_pkg::t_job    o_job
);

    logic [cdtv_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [cdtv_pkg::DECL_W-1:0] r_decl, n_decl;
    logic [cdtv_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_hdr_err, n_hdr_err;
    logic                        live;
    logic                        take;
    logic                        rec_done;

    logic [7:0] r_session;
    logic [3:0] r_adr;
    logic [7:0] r_point;
    logic [7:0] r_pmin;
    logic [7:0] r_psec;

    // Classify the current byte by its position in the file
    always_comb begin
        live      = (r_cnt < cdtv_pkg::CNT_W'(cdtv_pkg::MAX_TOC_BYTES));
        n_cnt     = live ? (r_cnt + cdtv_pkg::CNT_W'(1)) : r_cnt;
        n_decl    = r_decl;
        n_pos     = r_pos;
        n_hdr_err = r_hdr_err;
        take      = 1'b0;
        rec_done  = 1'b0;
        if (i_accept && live && !r_hdr_err) begin
            if (r_cnt == cdtv_pkg::CNT_W'(0)) begin
                n_decl = cdtv_pkg::DECL_W'({i_toc_byte, 8'h00});
            end else if (r_cnt == cdtv_pkg::CNT_W'(1)) begin
                n_decl = cdtv_pkg::DECL_W'({r_decl[15:8], i_toc_byte})
                         + cdtv_pkg::DECL_W'(2);
            end else if (r_cnt == cdtv_pkg::CNT_W'(2)) begin
                if (i_toc_byte != cdtv_pkg::FIRST_SESSION) begin
                    n_hdr_err = 1'b1;
                end
            end else if (r_cnt == cdtv_pkg::CNT_W'(3)) begin
                n_decl = r_decl;
            end else if (!(r_pos == cdtv_pkg::POS_W'(0)
                           && cdtv_pkg::DECL_W'(r_cnt) >= r_decl)) begin
                take = 1'b1;
                if (r_pos == cdtv_pkg::POS_W'(cdtv_pkg::REC_LEN - 1)) begin
                    n_pos    = cdtv_pkg::POS_W'(0);
                    rec_done = 1'b1;
                end else begin
                    n_pos = r_pos + cdtv_pkg::POS_W'(1);
                end
            end
        end
    end

    // Build the job beat
    always_comb begin
        o_job.rec_v     = rec_done;
        o_job.fin_v     = i_accept && i_is_last;
        o_job.too_large = (n_cnt >= cdtv_pkg::CNT_W'(cdtv_pkg::MAX_TOC_BYTES));
        o_job.hdr_err   = n_hdr_err;
        o_job.trunc     = (n_cnt < cdtv_pkg::CNT_W'(cdtv_pkg::HDR_LEN))
                          || (n_pos != cdtv_pkg::POS_W'(0))
                          || (cdtv_pkg::DECL_W'(n_cnt) < n_decl);
        o_job.session   = r_session;
        o_job.adr       = r_adr;
        o_job.point     = r_point;
        o_job.pmin      = r_pmin;
        o_job.psec      = r_psec;
        o_job.pframe    = i_toc_byte;
        o_job_push      = i_accept && (rec_done || i_is_last);
    end

    // Advance parse state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_decl    <= '0;
            r_pos     <= '0;
            r_hdr_err <= 1'b0;
        end else if (i_accept) begin
            if (i_is_last) begin
                r_cnt     <= '0;
                r_decl    <= '0;
                r_pos     <= '0;
                r_hdr_err <= 1'b0;
            end else begin
                r_cnt     <= n_cnt;
                r_decl    <= n_decl;
                r_pos     <= n_pos;
                r_hdr_err <= n_hdr_err;
            end
        end
    end

    // Capture the descriptor bytes the checks need
    always_ff @(posedge i_clk) begin
        if (take) begin
            case (r_pos)
                cdtv_pkg::POS_W'(0): r_session <= i_toc_byte;
                cdtv_pkg::POS_W'(1): r_adr     <= i_toc_byte[7:4];
                cdtv_pkg::POS_W'(3): r_point   <= i_toc_byte;
                cdtv_pkg::POS_W'(8): r_pmin    <= i_toc_byte;
                cdtv_pkg::POS_W'(9): r_psec    <= i_toc_byte;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/cdtv_job_fifo.sv =====
// Short job queue between the front end and the back end.
module cdtv_job_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cdtv_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cdtv_pkg::t_job  o_head
);

    cdtv_pkg::t_job                  r_mem [cdtv_pkg::FIFO_DEPTH];
    logic [cdtv_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [cdtv_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [cdtv_pkg::FIFO_PTR_W:0]   r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == (cdtv_pkg::FIFO_PTR_W + 1)'(cdtv_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + cdtv_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cdtv_pkg::FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (cdtv_pkg::FIFO_PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (cdtv_pkg::FIFO_PTR_W + 1)'(1);
            end
        end
    end

    // Write the job beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/cdtv_back.sv =====
// Back end: checks descriptors, tracks first error and leadout, forms the verdict.
module cdtv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_v,
    input  cdtv_pkg::t_job                i_job,
    output logic                          o_job_pop,
    input  logic [cdtv_pkg::IMG_W-1:0]    i_image_bytes,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_toc_valid,
    output logic [3:0]                    o_error_code,
    output logic signed [cdtv_pkg::LEAD_W-1:0] o_leadout_frames
);

    localparam int PM_F_W = 21;
    localparam int PS_F_W = 15;
    localparam int PM_B_W = 32;
    localparam int PS_B_W = 26;
    localparam int PF_B_W = 20;

    localparam int FRAMES_PER_MIN = 4500;
    localparam int FRAMES_PER_SEC = 75;
    localparam int LEAD_OFFSET    = 150;
    localparam int SECTOR_BYTES   = 2352;

    typedef struct packed {
        logic                rec_v;
        logic                fin_v;
        logic                too_large;
        logic                hdr_err;
        logic                trunc;
        cdtv_pkg::t_err      code;
        logic                a2;
        logic [PM_F_W-1:0]   pm_f;
        logic [PS_F_W-1:0]   ps_f;
        logic [7:0]          pf;
        logic [PM_B_W-1:0]   pm_b;
        logic [PS_B_W-1:0]   ps_b;
        logic [PF_B_W-1:0]   pf_b;
    } t_chk;

    // Check stage
    t_chk                                r_s1, n_s1;
    logic                                r_s1_v;
    logic                                s1_fire;
    logic                                s1_ready;

    // Running per-file state
    cdtv_pkg::t_err                      r_err, u_err;
    logic [cdtv_pkg::LEAD_W-1:0]         r_lead, u_lead;
    logic [cdtv_pkg::BYTES_W-1:0]        r_bytes, u_bytes;
    logic [cdtv_pkg::LEAD_W-1:0]         lead_sum;
    logic [cdtv_pkg::BYTES_W-1:0]        bytes_sum;
    cdtv_pkg::t_err                      fin_code;

    // Verdict stage
    logic                                r_fin_v;
    cdtv_pkg::t_err                      r_fin_code;
    logic                                r_fin_check;
    logic [cdtv_pkg::LEAD_W-1:0]         r_fin_lead;
    logic [cdtv_pkg::BYTES_W-1:0]        r_fin_bytes;
    logic                                fin_ready;

    // Output stage
    logic                                r_out_v;
    cdtv_pkg::t_err                      r_out_code;
    logic [cdtv_pkg::LEAD_W-1:0]         r_out_lead;
    cdtv_pkg::t_err                      out_code;
    logic                                out_ready;

    // Handshake chain from the result side back to the queue
    assign out_ready = !r_out_v || i_pop;
    assign fin_ready = !r_fin_v || out_ready;
    assign s1_fire   = r_s1_v && (!r_s1.fin_v || fin_ready);
    assign s1_ready  = !r_s1_v || s1_fire;
    assign o_job_pop = i_job_v && s1_ready;

    // Check the descriptor at the queue head and form partial products
    always_comb begin
        n_s1.rec_v     = i_job.rec_v;
        n_s1.fin_v     = i_job.fin_v;
        n_s1.too_large = i_job.too_large;
        n_s1.hdr_err   = i_job.hdr_err;
        n_s1.trunc     = i_job.trunc;
        n_s1.code      = cdtv_pkg::ERR_OK;
        n_s1.a2        = 1'b0;
        if (i_job.session != cdtv_pkg::FIRST_SESSION) begin
            n_s1.code = cdtv_pkg::ERR_SESSION;
        end else if (i_job.point >= cdtv_pkg::POINT_TRK_LO
                     && i_job.point <= cdtv_pkg::POINT_TRK_HI) begin
            if (i_job.adr == cdtv_pkg::ADR_POS
                && (i_job.psec > cdtv_pkg::SEC_LIMIT
                    || i_job.pframe > cdtv_pkg::FRAME_LIMIT)) begin
                n_s1.code = cdtv_pkg::ERR_TRACK_START;
            end
        end else if (i_job.point == cdtv_pkg::POINT_A0) begin
            if (i_job.adr != cdtv_pkg::ADR_POS) begin
                n_s1.code = cdtv_pkg::ERR_ADR;
            end else if (i_job.psec != cdtv_pkg::DISK_CDDA
                         && i_job.psec != cdtv_pkg::DISK_CDI
                         && i_job.psec != cdtv_pkg::DISK_XA) begin
                n_s1.code = cdtv_pkg::ERR_DISK_TYPE;
            end else if (i_job.pmin != 8'd1) begin
                n_s1.code = cdtv_pkg::ERR_FIRST_TRACK;
            end else if (i_job.pframe != 8'd0) begin
                n_s1.code = cdtv_pkg::ERR_RESERVED;
            end
        end else if (i_job.point == cdtv_pkg::POINT_A1) begin
            if (i_job.adr != cdtv_pkg::ADR_POS) begin
                n_s1.code = cdtv_pkg::ERR_ADR;
            end else if (i_job.pmin == 8'd0) begin
                n_s1.code = cdtv_pkg::ERR_LAST_TRACK;
            end else if (i_job.psec != 8'd0 || i_job.pframe != 8'd0) begin
                n_s1.code = cdtv_pkg::ERR_RESERVED;
            end
        end else if (i_job.point == cdtv_pkg::POINT_A2) begin
            if (i_job.adr != cdtv_pkg::ADR_POS) begin
                n_s1.code = cdtv_pkg::ERR_ADR;
            end else begin
                n_s1.a2 = 1'b1;
            end
        end else if (i_job.adr != cdtv_pkg::ADR_OTHER) begin
            n_s1.code = cdtv_pkg::ERR_ADR;
        end
        // Leadout in frames and in bytes, split into independent terms
        n_s1.pm_f = PM_F_W'(i_job.pmin) * PM_F_W'(FRAMES_PER_MIN);
        n_s1.ps_f = PS_F_W'(i_job.psec) * PS_F_W'(FRAMES_PER_SEC);
        n_s1.pf   = i_job.pframe;
        n_s1.pm_b = PM_B_W'(i_job.pmin) * PM_B_W'(FRAMES_PER_MIN * SECTOR_BYTES);
        n_s1.ps_b = PS_B_W'(i_job.psec) * PS_B_W'(FRAMES_PER_SEC * SECTOR_BYTES);
        n_s1.pf_b = PF_B_W'(i_job.pframe) * PF_B_W'(SECTOR_BYTES);
    end

    // Fold the checked descriptor into the running state
    always_comb begin
        lead_sum  = cdtv_pkg::LEAD_W'(r_s1.pm_f) + cdtv_pkg::LEAD_W'(r_s1.ps_f)
                    + cdtv_pkg::LEAD_W'(r_s1.pf) - cdtv_pkg::LEAD_W'(LEAD_OFFSET);
        bytes_sum = cdtv_pkg::BYTES_W'(r_s1.pm_b) + cdtv_pkg::BYTES_W'(r_s1.ps_b)
                    + cdtv_pkg::BYTES_W'(r_s1.pf_b)
                    - cdtv_pkg::BYTES_W'(LEAD_OFFSET * SECTOR_BYTES);
        u_err   = r_err;
        u_lead  = r_lead;
        u_bytes = r_bytes;
        if (r_s1.rec_v && r_err == cdtv_pkg::ERR_OK) begin
            if (r_s1.code != cdtv_pkg::ERR_OK) begin
                u_err = r_s1.code;
            end else if (r_s1.a2) begin
                u_lead  = lead_sum;
                u_bytes = bytes_sum;
            end
        end
        // Rank end-of-file outcomes; size check still pending when OK
        if (r_s1.too_large) begin
            fin_code = cdtv_pkg::ERR_TOO_LARGE;
        end else if (r_s1.hdr_err) begin
            fin_code = cdtv_pkg::ERR_FIRST_SESSION;
        end else if (u_err != cdtv_pkg::ERR_OK) begin
            fin_code = u_err;
        end else if (r_s1.trunc) begin
            fin_code = cdtv_pkg::ERR_TRUNCATED;
        end else begin
            fin_code = cdtv_pkg::ERR_OK;
        end
    end

    // Compare the leadout size against the image size
    always_comb begin
        if (!r_fin_check) begin
            out_code = r_fin_code;
        end else if (r_fin_lead[cdtv_pkg::LEAD_W-1]
                     || cdtv_pkg::IMG_W'(r_fin_bytes) != i_image_bytes) begin
            out_code = cdtv_pkg::ERR_SIZE;
        end else begin
            out_code = cdtv_pkg::ERR_OK;
        end
    end

    // Advance control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fin_v <= 1'b0;
            r_out_v <= 1'b0;
            r_err   <= cdtv_pkg::ERR_OK;
            r_lead  <= '0;
            r_bytes <= '0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_job_v;
            end
            if (s1_fire) begin
                if (r_s1.fin_v) begin
                    r_err   <= cdtv_pkg::ERR_OK;
                    r_lead  <= '0;
                    r_bytes <= '0;
                end else begin
                    r_err   <= u_err;
                    r_lead  <= u_lead;
                    r_bytes <= u_bytes;
                end
            end
            if (fin_ready) begin
                r_fin_v <= s1_fire && r_s1.fin_v;
            end
            if (out_ready) begin
                r_out_v <= r_fin_v;
            end
        end
    end

    // Hold payload beats as they move down the stages
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1 <= n_s1;
        end
        if (s1_fire && r_s1.fin_v) begin
            r_fin_code  <= fin_code;
            r_fin_check <= (fin_code == cdtv_pkg::ERR_OK);
            r_fin_lead  <= u_lead;
            r_fin_bytes <= u_bytes;
        end
        if (out_ready && r_fin_v) begin
            r_out_code <= out_code;
            r_out_lead <= r_fin_lead;
        end
    end

    assign o_empty          = !r_out_v;
    assign o_toc_valid      = (r_out_code == cdtv_pkg::ERR_OK);
    assign o_error_code     = r_out_code;
    assign o_leadout_frames = $signed(r_out_lead);

endmodule

// ===== tb/sv/cd_clone_toc_validator_tb.sv =====
// Self-checking testbench for the CD full-TOC validator: byte stream in, verdicts scored.
module cd_clone_toc_validator_tb;
    import cdtv_pkg::*;

    localparam longint SECTOR_BYTES   = 2352;
    localparam int     LEADIN_FRAMES  = 150;
    localparam int     SECS_PER_MIN   = 60;
    localparam int     FRAMES_PER_SEC = 75;
    localparam logic [7:0] FIRST_TRACK_NO = 8'd1;
    localparam int     DRAIN_CYCLES   = 8;
    localparam int     CYCLE_LIMIT    = 400000;
    localparam int     MAX_PRINTS     = 40;

    typedef struct {
        bit                ok;
        t_err              code;
        logic [LEAD_W-1:0] lead;
    } verdict_t;

    // Tracks the parse of each TOC file and scores the verdicts
    class toc_verdict_board;
        bit [IMG_W-1:0]  image_bytes;
        bit [11:0]       bytes_seen;
        bit [DECL_W-1:0] decl_len;
        bit [POS_W-1:0]  rec_pos;
        bit [7:0]        rec [REC_LEN];
        t_err            first_err;
        int              leadout;
        verdict_t        awaiting[$];
        int              mismatches;
        int              verdicts;
        int              code_hits[16];

        function new();
            image_bytes = '0;
            mismatches  = 0;
            verdicts    = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            bytes_seen = '0;
            decl_len   = '0;
            rec_pos    = '0;
            foreach (rec[i]) rec[i] = 8'h00;
            first_err  = ERR_OK;
            leadout    = 0;
        endfunction

        // Advance the parse by one accepted byte; queue a verdict on the last one
        function void note_byte(bit [7:0] b, bit last);
            int unsigned idx;
            bit [3:0]    adr;
            bit [7:0]    point;
            bit [7:0]    pmin;
            bit [7:0]    psec;
            bit [7:0]    pframe;
            t_err        err;
            verdict_t    v;
            if (bytes_seen < MAX_TOC_BYTES) begin
                idx = bytes_seen;
                bytes_seen++;
                if (first_err == ERR_OK) begin
                    if (idx == 0) begin
                        decl_len = DECL_W'(b) << 8;
                    end else if (idx == 1) begin
                        decl_len = (decl_len | DECL_W'(b)) + DECL_W'(2);
                    end else if (idx == 2) begin
                        if (b != FIRST_SESSION) first_err = ERR_FIRST_SESSION;
                    end else if (idx >= HDR_LEN && !(rec_pos == 0 && idx >= decl_len)) begin
                        rec[rec_pos] = b;
                        rec_pos++;
                        if (rec_pos == REC_LEN) begin
                            rec_pos = '0;
                            adr     = rec[1][7:4];
                            point   = rec[3];
                            pmin    = rec[8];
                            psec    = rec[9];
                            pframe  = rec[10];
                            // descriptor rules, first failing one wins
                            if (rec[0] != FIRST_SESSION) begin
                                err = ERR_SESSION;
                            end else if (point >= POINT_TRK_LO && point <= POINT_TRK_HI) begin
                                err = (adr == ADR_POS && (psec > SEC_LIMIT || pframe > FRAME_LIMIT))
                                      ? ERR_TRACK_START : ERR_OK;
                            end else if (point == POINT_A0) begin
                                if (adr != ADR_POS) err = ERR_ADR;
                                else if (!(psec inside {DISK_CDDA, DISK_CDI, DISK_XA}))
                                    err = ERR_DISK_TYPE;
                                else if (pmin != FIRST_TRACK_NO) err = ERR_FIRST_TRACK;
                                else if (pframe != 8'h00) err = ERR_RESERVED;
                                else err = ERR_OK;
                            end else if (point == POINT_A1) begin
                                if (adr != ADR_POS) err = ERR_ADR;
                                else if (pmin == 8'h00) err = ERR_LAST_TRACK;
                                else if (psec != 8'h00 || pframe != 8'h00) err = ERR_RESERVED;
                                else err = ERR_OK;
                            end else if (point == POINT_A2) begin
                                if (adr != ADR_POS) begin
                                    err = ERR_ADR;
                                end else begin
                                    leadout = (int'(pmin) * SECS_PER_MIN + int'(psec))
                                              * FRAMES_PER_SEC + int'(pframe) - LEADIN_FRAMES;
                                    err = ERR_OK;
                                end
                            end else begin
                                err = (adr != ADR_OTHER) ? ERR_ADR : ERR_OK;
                            end
                            first_err = err;
                        end
                    end
                end
            end
            if (last) begin
                if (bytes_seen >= MAX_TOC_BYTES) err = ERR_TOO_LARGE;
                else if (first_err != ERR_OK) err = first_err;
                else if (bytes_seen < HDR_LEN || rec_pos != 0 || bytes_seen < decl_len)
                    err = ERR_TRUNCATED;
                else if (leadout < 0 || longint'(leadout) * SECTOR_BYTES != longint'(image_bytes))
                    err = ERR_SIZE;
                else err = ERR_OK;
                v.ok   = (err == ERR_OK);
                v.code = err;
                v.lead = leadout[LEAD_W-1:0];
                awaiting.push_back(v);
                clear_parse();
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] verdict %0d: %s", $time, verdicts, what);
        endtask

        // Compare one popped verdict with the oldest expected one
        task check_verdict(logic ok, logic [3:0] code, logic [LEAD_W-1:0] lead);
            verdict_t v;
            if (awaiting.size() == 0) begin
                report($sformatf("unexpected verdict, code %0d", code));
                return;
            end
            v = awaiting.pop_front();
            verdicts++;
            code_hits[v.code]++;
            if (ok !== v.ok)
                report($sformatf("toc_valid %b, expected %b", ok, v.ok));
            if (code !== v.code)
                report($sformatf("error_code %0d, expected %0d", code, v.code));
            if (lead !== v.lead)
                report($sformatf("leadout_frames %h, expected %h", lead, v.lead));
        endtask

        task finish_check();
            foreach (awaiting[i])
                report($sformatf("verdict with code %0d never came", awaiting[i].code));
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [7:0]               i_toc_byte = 8'h00;
    logic                     i_is_last = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic                     o_toc_valid;
    logic [3:0]               o_error_code;
    logic signed [LEAD_W-1:0] o_leadout_frames;
    logic                     i_cfg_wr_en = 1'b0;
    logic [IMG_W-1:0]         i_cfg_wr_data = '0;

    toc_verdict_board board = new();
    bit [7:0]         toc_file[$];
    int               planned_lead;
    int               files_sent;
    int               bytes_sent;
    int               image_writes;
    int               cycle_count;

    cd_clone_toc_validator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_toc_byte      (i_toc_byte),
        .i_is_last       (i_is_last),
        .empty           (empty),
        .pop             (pop),
        .o_toc_valid     (o_toc_valid),
        .o_error_code    (o_error_code),
        .o_leadout_frames(o_leadout_frames),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint frames_to_bytes(int pmin, int psec, int pframe);
        return longint'((pmin * SECS_PER_MIN + psec) * FRAMES_PER_SEC + pframe - LEADIN_FRAMES)
               * SECTOR_BYTES;
    endfunction

    function automatic void start_file();
        toc_file.delete();
        planned_lead = 0;
    endfunction

    function automatic void put_header(int unsigned len_field, bit [7:0] first_sess);
        toc_file.push_back(len_field[15:8]);
        toc_file.push_back(len_field[7:0]);
        toc_file.push_back(first_sess);
        toc_file.push_back(8'($urandom_range(255)));
    endfunction

    // Append one descriptor; unchecked bytes get random content
    function automatic void put_desc(bit [7:0] sess, bit [3:0] adr, bit [7:0] point,
                                     bit [7:0] pmin, bit [7:0] psec, bit [7:0] pframe);
        toc_file.push_back(sess);
        toc_file.push_back({adr, 4'($urandom_range(15))});
        toc_file.push_back(8'($urandom_range(255)));
        toc_file.push_back(point);
        repeat (4) toc_file.push_back(8'($urandom_range(255)));
        toc_file.push_back(pmin);
        toc_file.push_back(psec);
        toc_file.push_back(pframe);
        if (point == POINT_A2 && adr == ADR_POS)
            planned_lead = (int'(pmin) * SECS_PER_MIN + int'(psec)) * FRAMES_PER_SEC
                           + int'(pframe) - LEADIN_FRAMES;
    endfunction

    function automatic void put_random_desc(bit want_a2);
        int       kind;
        bit [7:0] point;
        kind = want_a2 ? 6 : $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                put_desc(FIRST_SESSION, ADR_POS, 8'($urandom_range(POINT_TRK_LO, POINT_TRK_HI)),
                         8'($urandom_range(255)), 8'($urandom_range(SEC_LIMIT)),
                         8'($urandom_range(FRAME_LIMIT)));
            end
            3: begin
                put_desc(FIRST_SESSION, 4'($urandom_range(15)),
                         8'($urandom_range(POINT_TRK_LO, POINT_TRK_HI)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            end
            4: begin
                case ($urandom_range(2))
                    0: point = DISK_CDDA;
                    1: point = DISK_CDI;
                    default: point = DISK_XA;
                endcase
                put_desc(FIRST_SESSION, ADR_POS, POINT_A0, FIRST_TRACK_NO, point, 8'h00);
            end
            5: begin
                put_desc(FIRST_SESSION, ADR_POS, POINT_A1, 8'($urandom_range(1, 99)),
                         8'h00, 8'h00);
            end
            6, 9: begin
                put_desc(FIRST_SESSION, ADR_POS, POINT_A2,
                         8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(79)),
                         8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(59)),
                         8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(74)));
            end
            default: begin
                case ($urandom_range(2))
                    0: point = 8'h00;
                    1: point = 8'($urandom_range(POINT_TRK_HI + 1, POINT_A0 - 1));
                    default: point = 8'($urandom_range(POINT_A2 + 1, 8'hFF));
                endcase
                put_desc(FIRST_SESSION, ADR_OTHER, point, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        endcase
    endfunction

    // Mostly well-formed files with random content, some broken, some plain noise
    function automatic void build_random_file();
        int shape;
        int n;
        int a2_at;
        shape = $urandom_range(99);
        start_file();
        if (shape < 10) begin
            repeat ($urandom_range(1, 40)) toc_file.push_back(8'($urandom_range(255)));
        end else begin
            n     = $urandom_range(1, 4);
            a2_at = $urandom_range(n - 1);
            put_header(REC_LEN * n + 2, FIRST_SESSION);
            for (int i = 0; i < n; i++) put_random_desc(i == a2_at);
            if (shape >= 64 && shape < 72) begin
                repeat ($urandom_range(1, 5)) toc_file.push_back(8'($urandom_range(255)));
            end else if (shape >= 72) begin
                case ($urandom_range(3))
                    0: toc_file[$urandom_range(toc_file.size() - 1)] ^= 8'($urandom_range(1, 255));
                    1: repeat ($urandom_range(1, toc_file.size() - 1)) void'(toc_file.pop_back());
                    2: toc_file[2] = 8'(($urandom_range(254) + 2) % 256);
                    default: begin
                        toc_file[0] = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
                        toc_file[1] = 8'($urandom_range(255));
                    end
                endcase
            end
        end
    endfunction

    function automatic bit [IMG_W-1:0] pick_image_bytes();
        int     r;
        longint matched;
        r       = $urandom_range(99);
        matched = longint'(planned_lead) * SECTOR_BYTES;
        if (r < 60 && planned_lead >= 0) return IMG_W'(matched);
        if (r < 70) return IMG_W'(matched + $urandom_range(1, SECTOR_BYTES));
        if (r < 80) return IMG_W'({$urandom, $urandom});
        if (r < 88) return '0;
        if (r < 95) return '1;
        return IMG_W'(matched);
    endfunction

    // Hold off until every verdict is out, then let the pipeline drain
    task automatic wait_idle();
        while (board.awaiting.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_image_bytes(bit [IMG_W-1:0] value);
        // drop the byte request while the block drains
        push <= 1'b0;
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.image_bytes = value;
        image_writes++;
    endtask

    // Drive one byte beat and wait until it is taken
    task automatic push_byte(bit [7:0] b, bit last, int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_toc_byte <= b;
        i_is_last  <= last;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        board.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_file(bit steady);
        for (int i = 0; i < toc_file.size(); i++)
            push_byte(toc_file[i], i == toc_file.size() - 1,
                      steady ? 0 : $urandom_range(8));
        files_sent++;
    endtask

    task automatic one_desc_case(bit [7:0] sess, bit [3:0] adr, bit [7:0] point,
                                 bit [7:0] pmin, bit [7:0] psec, bit [7:0] pframe,
                                 longint img);
        start_file();
        put_header(REC_LEN + 2, FIRST_SESSION);
        put_desc(sess, adr, point, pmin, psec, pframe);
        set_image_bytes(IMG_W'(img));
        send_file($urandom_range(1));
    endtask

    task automatic padded_file(int total, longint img);
        start_file();
        put_header(REC_LEN + 2, FIRST_SESSION);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A2, 8'd1, 8'd0, 8'd0);
        while (toc_file.size() < total) toc_file.push_back(8'($urandom_range(255)));
        set_image_bytes(IMG_W'(img));
        send_file(1);
    endtask

    // Verdict side: random pop stalls, with calm stretches
    initial begin
        int stall;
        bit calm;
        calm = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(15) == 0) calm = ~calm;
            stall = calm ? 0 : $urandom_range(8);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty !== 1'b0) @(posedge i_clk);
            board.check_verdict(o_toc_valid, o_error_code, o_leadout_frames);
        end
    end

    initial begin
        int rand_files;
        int rand_bytes;
        int codes_seen;
        rand_files = 0;
        rand_bytes = 0;
        codes_seen = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single byte: ends inside the header
        start_file();
        toc_file.push_back(8'h00);
        send_file(1);
        // Header only, zero length field
        start_file();
        put_header(0, FIRST_SESSION);
        send_file(0);
        // Clean leadout at zero frames against an image size of zero
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A2, 8'd0, 8'd2, 8'd0, 0);
        // Bad first session
        start_file();
        put_header(REC_LEN + 2, 8'h02);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A2, 8'd0, 8'd2, 8'd0);
        send_file(0);
        // Descriptor rules
        one_desc_case(8'h00, ADR_POS, POINT_A2, 8'd0, 8'd2, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_TRK_HI, 8'd0, 8'd61, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_TRK_LO, 8'd0, 8'd60, 8'd76, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_TRK_LO, 8'hFF, SEC_LIMIT, FRAME_LIMIT, 0);
        one_desc_case(FIRST_SESSION, ADR_OTHER, POINT_A0, FIRST_TRACK_NO, DISK_CDDA, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A0, FIRST_TRACK_NO, 8'h30, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A0, 8'd2, DISK_XA, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A0, FIRST_TRACK_NO, DISK_CDI, 8'd1, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A0, FIRST_TRACK_NO, DISK_CDDA, 8'd0, 0);
        one_desc_case(FIRST_SESSION, 4'd0, POINT_A1, 8'd1, 8'd0, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A1, 8'd0, 8'd0, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A1, 8'd1, 8'd1, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A1, 8'd99, 8'd0, 8'd0, 0);
        one_desc_case(FIRST_SESSION, 4'd2, POINT_A2, 8'd0, 8'd2, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, 8'hB0, 8'd0, 8'd0, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_OTHER, 8'h00, 8'd0, 8'd0, 8'd0, 0);
        // Negative leadout, largest leadout, all-ones image size
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A2, 8'd0, 8'd0, 8'd0, 0);
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A2, 8'hFF, 8'hFF, 8'hFF,
                      frames_to_bytes(255, 255, 255));
        one_desc_case(FIRST_SESSION, ADR_POS, POINT_A2, 8'd0, 8'd2, 8'd0, -1);
        // First error wins: later leadout is not taken
        start_file();
        put_header(REC_LEN * 3 + 2, FIRST_SESSION);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A2, 8'd10, 8'd0, 8'd0);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A1, 8'd0, 8'd0, 8'd0);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A2, 8'd20, 8'd0, 8'd0);
        send_file(0);
        // Ends inside a descriptor, and before a descriptor the length calls for
        start_file();
        put_header(REC_LEN + 2, FIRST_SESSION);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A2, 8'd0, 8'd2, 8'd0);
        repeat (3) void'(toc_file.pop_back());
        send_file(0);
        start_file();
        put_header(REC_LEN * 2 + 2, FIRST_SESSION);
        put_desc(FIRST_SESSION, ADR_POS, POINT_A2, 8'd0, 8'd2, 8'd0);
        send_file(0);
        // Trailing bytes are ignored; a file exactly at the size limit
        padded_file(REC_LEN + HDR_LEN + 4, frames_to_bytes(1, 0, 0));
        padded_file(MAX_TOC_BYTES, frames_to_bytes(1, 0, 0));

        // Random files, some behind an image size change
        while (rand_files < 16 || rand_bytes < 400) begin
            build_random_file();
            if ($urandom_range(1) == 0) set_image_bytes(pick_image_bytes());
            rand_bytes += toc_file.size();
            send_file($urandom_range(3) == 0);
            rand_files++;
        end
        push <= 1'b0;

        wait_idle();
        foreach (board.code_hits[i]) if (board.code_hits[i] > 0) codes_seen++;
        $display("Sent %0d TOC files (%0d bytes) over %0d image size writes",
                 files_sent, bytes_sent, image_writes);
        $display("Checked %0d verdicts covering %0d distinct error codes",
                 board.verdicts, codes_seen);
        board.finish_check();
        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
